### rtl/core/ilha_pkg.sv
package ilha_pkg;

  // Opcodes carried in the input tuser
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_GROW  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  // Field and register widths
  localparam int GROW_W  = 16;
  localparam int LIMIT_W = 17;
  localparam int CFG_W   = 17;
  localparam int SIZE_W  = 16;
  localparam int ADDR_W  = 16;
  localparam int TAG_W   = 32;

  // Reset values
  localparam int DEF_HEAP_WORDS = 16384;
  localparam logic [GROW_W-1:0]  GROW_RST  = 16'd4096;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 17'd65536;
  localparam logic [LIMIT_W-1:0] BRK_RST   = 17'd4112;

  // Initial heap image: prologue tags, one free 4096-byte block, epilogue
  localparam int INIT_N = 5;

  function automatic logic [19:0] init_word(input logic [2:0] k);
    case (k)
      3'd0:    init_word = 20'd1;
      3'd1:    init_word = 20'd2;
      3'd2:    init_word = 20'd3;
      3'd3:    init_word = 20'd1026;
      3'd4:    init_word = 20'd1027;
      default: init_word = 20'd0;
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] init_value(input logic [2:0] k);
    case (k)
      3'd0:    init_value = 32'd9;
      3'd1:    init_value = 32'd9;
      3'd2:    init_value = 32'd4096;
      3'd3:    init_value = 32'd4096;
      3'd4:    init_value = 32'd1;
      default: init_value = 32'd0;
    endcase
  endfunction

endpackage

### rtl/core/implicit_list_heap_allocator.sv
// First-fit heap allocator with boundary tags kept in a single-port word memory of
// HEAP_WORDS 32-bit words. After reset the block clears the memory, one word a cycle,
// then writes the prologue, one free 4096-byte block and the epilogue; in_tready stays
// low until then (configuration writes are taken). Items are handled one at a time by a
// sequencer around the memory port. Every tag read or write passes through an issue
// step, an index step and the memory access, with a quotient step and a remainder step
// before the access when the byte address lies beyond the memory and its word index is
// wrapped with a reciprocal multiply. A free rewrites both tags without the allocated
// bit, then merges with whichever neighbors are free. An allocate walks the blocks first
// fit, then places the block, splitting off the remainder when it is large enough; when
// the heap has to grow, it writes the new tags and merges the new block before placing.
// Refused growth answers with an out-of-memory status once the walk ends, and a zero-size
// request answers without a memory access. A result that is not taken holds the sequencer.
module implicit_list_heap_allocator #(
  parameter int HEAP_WORDS = ilha_pkg::DEF_HEAP_WORDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,    // request_size, block_address
  input  logic [0:0]                    in_tuser,    // opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ilha_pkg::ADDR_W-1:0]   out_tdata,   // payload_address
  output logic [1:0]                    out_tuser,   // status
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_addr,
  input  logic [ilha_pkg::CFG_W-1:0]    cfg_wdata
);
  import ilha_pkg::*;

  localparam int IW = $clog2(HEAP_WORDS);
  localparam logic [31:0] CAP = 32'(HEAP_WORDS * 4);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / HEAP_WORDS);

  typedef enum logic [5:0] {
    S_CLR, S_INIT, S_IDLE, S_ADDR, S_MOD, S_MODF, S_ACC, S_DONE,
    S_F1, S_F2, S_F3,
    S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_MG5,
    S_C1B, S_C2B, S_C2C, S_C3B, S_C3C, S_C3D, S_PV, S_PV2, S_MRET,
    S_A0, S_A1, S_A2,
    S_G0, S_G1, S_G2, S_G3, S_G4,
    S_PB0, S_PB1, S_PB2, S_PB3, S_PB4, S_PB5, S_PB6, S_PBR
  } state_t;

  typedef struct packed {
    logic [31:0] addr;
    logic        we;
    logic [31:0] data;
    state_t      ret;
  } acc_t;

  state_t               state_r;
  acc_t                 acc_r;
  logic [IW-1:0]        idx_r;
  logic [29:0]          quo_r;
  logic [IW:0]          rem_r;
  logic [IW-1:0]        clr_r;
  logic [2:0]           init_r;
  logic [TAG_W-1:0]     mem [HEAP_WORDS];
  logic [TAG_W-1:0]     rdata_r;

  logic [GROW_W-1:0]    grow_step_r;
  logic [LIMIT_W-1:0]   heap_limit_r;
  logic [LIMIT_W-1:0]   brk_r;

  logic [ADDR_W-1:0]    ba_r;
  logic [16:0]          asz_r;
  logic [31:0]          p_r, pv_r, bpv_r, szp_r, sz_r, ps_r, nx2_r;
  logic                 pa_r;
  logic                 in_grow_r;
  logic [32:0]          q_r;
  logic [17:0]          gsz_r;
  logic [ADDR_W-1:0]    res_addr_r;
  logic [1:0]           res_status_r;
  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [1:0]           out_status_r;

  logic [31:0]          tag;
  logic [31:0]          asz32;
  logic [16:0]          asz_in;
  logic [29:0]          word;
  logic [61:0]          mod_prod;
  logic [31:0]          mod_qn;
  logic [31:0]          mod_diff;
  logic [16:0]          grow_bytes;
  logic [15:0]          grow_words;
  logic [31:0]          lim;
  logic                 mem_we;
  logic                 mem_re;
  logic [IW-1:0]        mem_idx;
  logic [TAG_W-1:0]     mem_wd;

  // Size field of the last tag read, and common widened values
  assign tag    = {rdata_r[31:3], 3'b000};
  assign asz32  = {15'd0, asz_r};
  assign asz_in = ({1'b0, in_tdata[15:0]} + 17'd15) & ~17'd7;
  assign word   = acc_r.addr[31:2];

  // Word-index wrap: estimate the quotient by reciprocal, then take the remainder
  always_comb begin
    mod_prod = {32'd0, word} * {30'd0, RECIP};
    mod_qn   = {2'b00, quo_r} * 32'(HEAP_WORDS);
    mod_diff = {2'b00, word} - mod_qn;
  end

  // Growth amount and effective limit
  always_comb begin
    grow_bytes = (asz_r > {1'b0, grow_step_r}) ? asz_r : {1'b0, grow_step_r};
    grow_words = {1'b0, grow_bytes[16:2]} + {15'd0, grow_bytes[2]};
    lim = ({15'd0, heap_limit_r} > CAP) ? CAP : {15'd0, heap_limit_r};
  end

  // Memory port select
  always_comb begin
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    mem_idx = idx_r;
    mem_wd  = acc_r.data;
    case (state_r)
      S_CLR: begin
        mem_we  = 1'b1;
        mem_idx = clr_r;
        mem_wd  = '0;
      end
      S_INIT: begin
        mem_we  = 1'b1;
        mem_idx = IW'(init_word(init_r));
        mem_wd  = init_value(init_r);
      end
      S_ACC: begin
        mem_we = acc_r.we;
        mem_re = !acc_r.we;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_idx] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_idx];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grow_step_r  <= GROW_RST;
      heap_limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_GROW:  grow_step_r  <= cfg_wdata[GROW_W-1:0];
        CFG_LIMIT: heap_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      init_r      <= '0;
      brk_r       <= BRK_RST;
      out_valid_r <= 1'b0;
    end else begin
      // drop a result once taken, unless a new one is loaded
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IW'(HEAP_WORDS - 1)) begin
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          init_r <= init_r + 1'b1;
          if (init_r == 3'(INIT_N - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            ba_r  <= in_tdata[31:16];
            asz_r <= asz_in;
            if (in_tuser[0] == OP_FREE) begin
              acc_r   <= '{addr: {16'd0, in_tdata[31:16]} - 32'd4, we: 1'b0, data: '0,
                           ret: S_F1};
              state_r <= S_ADDR;
            end else if (in_tdata[15:0] == '0) begin
              res_addr_r   <= '0;
              res_status_r <= ST_ZERO;
              state_r      <= S_DONE;
            end else begin
              acc_r   <= '{addr: 32'd4, we: 1'b0, data: '0, ret: S_A0};
              state_r <= S_ADDR;
            end
          end
        end

        // word index: direct, or wrapped through the reciprocal
        S_ADDR: begin
          if (word < 30'(HEAP_WORDS)) begin
            idx_r   <= word[IW-1:0];
            state_r <= S_ACC;
          end else begin
            quo_r   <= mod_prod[61:32];
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          rem_r   <= mod_diff[IW:0];
          state_r <= S_MODF;
        end
        S_MODF: begin
          idx_r   <= (rem_r >= (IW+1)'(HEAP_WORDS)) ? IW'(rem_r - (IW+1)'(HEAP_WORDS))
                                                   : rem_r[IW-1:0];
          state_r <= S_ACC;
        end
        S_ACC: begin
          state_r <= acc_r.ret;
        end

        // free: rewrite both tags without the allocated bit
        S_F1: begin
          sz_r    <= tag;
          acc_r   <= '{addr: {16'd0, ba_r} - 32'd4, we: 1'b1, data: tag, ret: S_F2};
          state_r <= S_ADDR;
        end
        S_F2: begin
          acc_r   <= '{addr: {16'd0, ba_r} + sz_r - 32'd8, we: 1'b1, data: sz_r, ret: S_F3};
          state_r <= S_ADDR;
        end
        S_F3: begin
          p_r       <= {16'd0, ba_r};
          in_grow_r <= 1'b0;
          state_r   <= S_MG0;
        end

        // merge: gather neighbor tags
        S_MG0: begin
          acc_r   <= '{addr: p_r - 32'd8, we: 1'b0, data: '0, ret: S_MG1};
          state_r <= S_ADDR;
        end
        S_MG1: begin
          pv_r    <= p_r - tag;
          acc_r   <= '{addr: p_r - tag - 32'd4, we: 1'b0, data: '0, ret: S_MG2};
          state_r <= S_ADDR;
        end
        S_MG2: begin
          bpv_r   <= tag;
          acc_r   <= '{addr: pv_r + tag - 32'd8, we: 1'b0, data: '0, ret: S_MG3};
          state_r <= S_ADDR;
        end
        S_MG3: begin
          pa_r    <= rdata_r[0];
          acc_r   <= '{addr: p_r - 32'd4, we: 1'b0, data: '0, ret: S_MG4};
          state_r <= S_ADDR;
        end
        S_MG4: begin
          szp_r   <= tag;
          acc_r   <= '{addr: p_r + tag - 32'd4, we: 1'b0, data: '0, ret: S_MG5};
          state_r <= S_ADDR;
        end
        S_MG5: begin
          if (pa_r && !rdata_r[0]) begin
            sz_r    <= szp_r + tag;
            acc_r   <= '{addr: p_r - 32'd4, we: 1'b1, data: szp_r + tag, ret: S_C1B};
            state_r <= S_ADDR;
          end else if (!pa_r && rdata_r[0]) begin
            sz_r    <= szp_r + bpv_r;
            acc_r   <= '{addr: p_r + szp_r - 32'd8, we: 1'b1, data: szp_r + bpv_r,
                         ret: S_C2B};
            state_r <= S_ADDR;
          end else if (!pa_r && !rdata_r[0]) begin
            sz_r    <= szp_r + bpv_r + tag;
            acc_r   <= '{addr: pv_r - 32'd4, we: 1'b1, data: szp_r + bpv_r + tag,
                         ret: S_C3B};
            state_r <= S_ADDR;
          end else begin
            state_r <= S_MRET;
          end
        end

        // merge with next block
        S_C1B: begin
          acc_r   <= '{addr: p_r + {sz_r[31:3], 3'b000} - 32'd8, we: 1'b1, data: sz_r,
                       ret: S_MRET};
          state_r <= S_ADDR;
        end

        // merge with previous block
        S_C2B: begin
          acc_r   <= '{addr: p_r - 32'd8, we: 1'b0, data: '0, ret: S_C2C};
          state_r <= S_ADDR;
        end
        S_C2C: begin
          acc_r   <= '{addr: p_r - tag - 32'd4, we: 1'b1, data: sz_r, ret: S_PV};
          state_r <= S_ADDR;
        end

        // merge with both neighbors
        S_C3B: begin
          acc_r   <= '{addr: p_r - 32'd4, we: 1'b0, data: '0, ret: S_C3C};
          state_r <= S_ADDR;
        end
        S_C3C: begin
          nx2_r   <= p_r + tag;
          acc_r   <= '{addr: p_r + tag - 32'd4, we: 1'b0, data: '0, ret: S_C3D};
          state_r <= S_ADDR;
        end
        S_C3D: begin
          acc_r   <= '{addr: nx2_r + tag - 32'd8, we: 1'b1, data: sz_r, ret: S_PV};
          state_r <= S_ADDR;
        end

        // step back to the previous block
        S_PV: begin
          acc_r   <= '{addr: p_r - 32'd8, we: 1'b0, data: '0, ret: S_PV2};
          state_r <= S_ADDR;
        end
        S_PV2: begin
          p_r     <= p_r - tag;
          state_r <= S_MRET;
        end
        S_MRET: begin
          if (in_grow_r) begin
            state_r <= S_PB0;
          end else begin
            res_addr_r   <= '0;
            res_status_r <= ST_OK;
            state_r      <= S_DONE;
          end
        end

        // first-fit walk
        S_A0: begin
          q_r     <= 33'd8 + {1'b0, tag};
          state_r <= S_A1;
        end
        S_A1: begin
          if (q_r < {16'd0, brk_r}) begin
            acc_r   <= '{addr: q_r[31:0] - 32'd4, we: 1'b0, data: '0, ret: S_A2};
            state_r <= S_ADDR;
          end else begin
            state_r <= S_G0;
          end
        end
        S_A2: begin
          if (tag == '0) begin
            state_r <= S_G0;
          end else if (!rdata_r[0] && tag >= asz32) begin
            p_r     <= q_r[31:0];
            state_r <= S_PB0;
          end else begin
            q_r     <= q_r + {1'b0, tag};
            state_r <= S_A1;
          end
        end

        // grow the heap
        S_G0: begin
          gsz_r   <= {grow_words, 2'b00};
          state_r <= S_G1;
        end
        S_G1: begin
          if ({15'd0, brk_r} + {14'd0, gsz_r} > lim) begin
            res_addr_r   <= '0;
            res_status_r <= ST_OOM;
            state_r      <= S_DONE;
          end else begin
            p_r     <= {15'd0, brk_r};
            brk_r   <= 17'({1'b0, brk_r} + gsz_r);
            acc_r   <= '{addr: {15'd0, brk_r} - 32'd4, we: 1'b1, data: {14'd0, gsz_r},
                         ret: S_G2};
            state_r <= S_ADDR;
          end
        end
        S_G2: begin
          acc_r   <= '{addr: p_r + {14'd0, gsz_r} - 32'd8, we: 1'b1, data: {14'd0, gsz_r},
                       ret: S_G3};
          state_r <= S_ADDR;
        end
        S_G3: begin
          acc_r   <= '{addr: p_r + {14'd0, gsz_r} - 32'd4, we: 1'b1, data: 32'd1,
                       ret: S_G4};
          state_r <= S_ADDR;
        end
        S_G4: begin
          in_grow_r <= 1'b1;
          state_r   <= S_MG0;
        end

        // place the block, splitting off a large remainder
        S_PB0: begin
          acc_r   <= '{addr: p_r - 32'd4, we: 1'b0, data: '0, ret: S_PB1};
          state_r <= S_ADDR;
        end
        S_PB1: begin
          ps_r <= tag;
          if (tag - asz32 >= 32'd16) begin
            acc_r <= '{addr: p_r + tag - 32'd8, we: 1'b1, data: tag - asz32, ret: S_PB2};
          end else begin
            acc_r <= '{addr: p_r - 32'd4, we: 1'b1, data: tag | 32'd1, ret: S_PB5};
          end
          state_r <= S_ADDR;
        end
        S_PB2: begin
          acc_r   <= '{addr: p_r - 32'd4, we: 1'b1, data: asz32 | 32'd1, ret: S_PB3};
          state_r <= S_ADDR;
        end
        S_PB3: begin
          acc_r   <= '{addr: p_r + asz32 - 32'd4, we: 1'b1, data: ps_r - asz32, ret: S_PB4};
          state_r <= S_ADDR;
        end
        // reread the header, since the remainder header may land on it
        S_PB4: begin
          acc_r   <= '{addr: p_r - 32'd4, we: 1'b0, data: '0, ret: S_PB6};
          state_r <= S_ADDR;
        end
        S_PB6: begin
          acc_r   <= '{addr: p_r + tag - 32'd8, we: 1'b1, data: asz32 | 32'd1,
                       ret: S_PBR};
          state_r <= S_ADDR;
        end
        S_PB5: begin
          acc_r   <= '{addr: p_r + ps_r - 32'd8, we: 1'b1, data: ps_r | 32'd1, ret: S_PBR};
          state_r <= S_ADDR;
        end
        S_PBR: begin
          res_addr_r   <= p_r[ADDR_W-1:0];
          res_status_r <= ST_OK;
          state_r      <= S_DONE;
        end

        // hand the result to the output register
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_addr_r   <= res_addr_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

endmodule

### tb/tb_top.sv
module tb_top;
  import ilha_pkg::*;

  localparam int NWORDS = DEF_HEAP_WORDS;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;     // request_size, block_address
  logic [0:0] in_tuser = '0;      // opcode
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ADDR_W-1:0] out_tdata;   // payload_address
  logic [1:0] out_tuser;          // status
  logic cfg_we = 1'b0;
  logic [0:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  implicit_list_heap_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Shadow heap and allocator state
  logic [31:0] shadow_heap [0:NWORDS-1];
  logic [31:0] shadow_brk;
  logic [31:0] shadow_grow;
  logic [31:0] shadow_limit;

  alloc_result_t expected_results[$];
  logic [ADDR_W-1:0] live_blocks[$];
  int err_count = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;
  int hold_cycles = 0;

  function automatic logic [31:0] tag_rd(input logic [31:0] a);
    return shadow_heap[a[15:2]];
  endfunction

  function automatic void tag_wr(input logic [31:0] a, input logic [31:0] v);
    shadow_heap[a[15:2]] = v;
  endfunction

  function automatic logic [31:0] blk_size(input logic [31:0] p);
    return tag_rd(p - 32'd4) & ~32'd7;
  endfunction

  function automatic logic [31:0] blk_next(input logic [31:0] p);
    return p + blk_size(p);
  endfunction

  function automatic logic [31:0] blk_prev(input logic [31:0] p);
    return p - (tag_rd(p - 32'd8) & ~32'd7);
  endfunction

  function automatic logic [31:0] blk_foot(input logic [31:0] p);
    return p + blk_size(p) - 32'd8;
  endfunction

  // Coalesce with free neighbors, return the merged block
  function automatic logic [31:0] coalesce(input logic [31:0] p);
    logic pa, na;
    logic [31:0] sz;
    logic [31:0] t;
    t = tag_rd(blk_foot(blk_prev(p)));
    pa = t[0];
    t = tag_rd(blk_next(p) - 32'd4);
    na = t[0];
    sz = blk_size(p);
    if (pa && !na) begin
      sz += blk_size(blk_next(p));
      tag_wr(p - 32'd4, sz);
      tag_wr(blk_foot(p), sz);
    end else if (!pa && na) begin
      sz += blk_size(blk_prev(p));
      tag_wr(blk_foot(p), sz);
      tag_wr(blk_prev(p) - 32'd4, sz);
      p = blk_prev(p);
    end else if (!pa && !na) begin
      sz += blk_size(blk_prev(p)) + blk_size(blk_next(p));
      tag_wr(blk_prev(p) - 32'd4, sz);
      tag_wr(blk_foot(blk_next(p)), sz);
      p = blk_prev(p);
    end
    return p;
  endfunction

  function automatic bit heap_extend(input logic [31:0] bytes, output logic [31:0] blk);
    logic [31:0] words, sz, lim, p;
    words = bytes >> 2;
    sz = (words + (words & 32'd1)) << 2;
    lim = shadow_limit;
    if (lim > 32'(NWORDS * 4)) lim = 32'(NWORDS * 4);
    blk = '0;
    if ({32'd0, shadow_brk} + {32'd0, sz} > {32'd0, lim}) return 1'b0;
    p = shadow_brk;
    shadow_brk += sz;
    tag_wr(p - 32'd4, sz);
    tag_wr(p + sz - 32'd8, sz);
    tag_wr(p + sz - 32'd4, 32'd1);
    blk = coalesce(p);
    return 1'b1;
  endfunction

  function automatic void place_block(input logic [31:0] p, input logic [31:0] asz);
    logic [31:0] ps;
    ps = blk_size(p);
    if (ps - asz >= 32'd16) begin
      tag_wr(blk_foot(p), ps - asz);
      tag_wr(p - 32'd4, asz | 32'd1);
      tag_wr(blk_next(p) - 32'd4, ps - asz);
      tag_wr(blk_foot(p), asz | 32'd1);
    end else begin
      tag_wr(p - 32'd4, ps | 32'd1);
      tag_wr(blk_foot(p), ps | 32'd1);
    end
  endfunction

  function automatic alloc_result_t predict_alloc(input logic op, input logic [15:0] rs,
                                                  input logic [15:0] ba);
    alloc_result_t r;
    logic [31:0] sz, asz, t, s, p, b;
    logic [63:0] q;
    bit found;
    r = '0;
    if (op == OP_FREE) begin
      b = {16'd0, ba};
      sz = blk_size(b);
      tag_wr(b - 32'd4, sz);
      tag_wr(b + sz - 32'd8, sz);
      p = coalesce(b);
      return r;
    end
    if (rs == 16'd0) begin
      r.status = ST_ZERO;
      return r;
    end
    asz = ({16'd0, rs} + 32'd15) & ~32'd7;
    q = 64'd8 + {32'd0, tag_rd(32'd4) & ~32'd7};
    found = 1'b0;
    // First-fit walk over block headers
    while (!found && q < {32'd0, shadow_brk}) begin
      t = tag_rd(q[31:0] - 32'd4);
      s = t & ~32'd7;
      if (s == 32'd0) break;
      if (!t[0] && s >= asz) begin
        place_block(q[31:0], asz);
        r.addr = q[15:0];
        found = 1'b1;
      end else begin
        q += {32'd0, s};
      end
    end
    if (found) return r;
    if (!heap_extend(asz > shadow_grow ? asz : shadow_grow, p)) begin
      r.status = ST_OOM;
      return r;
    end
    place_block(p, asz);
    r.addr = p[15:0];
    return r;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < NWORDS; i++) shadow_heap[i] = '0;
    shadow_heap[1] = 32'd9;
    shadow_heap[2] = 32'd9;
    shadow_heap[3] = 32'd4096;
    shadow_heap[1026] = 32'd4096;
    shadow_heap[1027] = 32'd1;
    shadow_brk = 32'd4112;
    shadow_grow = 32'd4096;
    shadow_limit = 32'd65536;
  endfunction

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: long hold-off on request, random stall bursts otherwise
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 11) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: payload_address %0d status %0d",
               out_tdata, out_tuser);
        err_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata !== exp_r.addr) begin
          $error("payload_address expected %0d actual %0d", exp_r.addr, out_tdata);
          err_count++;
        end
        if (out_tuser !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_tuser);
          err_count++;
        end
      end
    end
  end

  // Send one beat, predict its result, then maybe idle
  task automatic send_item(input logic op, input logic [15:0] rs, input logic [15:0] ba);
    alloc_result_t r;
    int gap;
    r = predict_alloc(op, rs, ba);
    expected_results.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK) live_blocks.push_back(r.addr);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {ba, rs};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_alloc(input logic [15:0] rs);
    send_item(OP_ALLOC, rs, 16'($urandom()));
  endtask

  // Free a random live block, or allocate when none is live
  task automatic send_free_live();
    int k;
    logic [15:0] a;
    if (live_blocks.size() == 0) begin
      send_alloc(16'($urandom_range(1, 64)));
      return;
    end
    k = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[k];
    live_blocks.delete(k);
    send_item(OP_FREE, 16'($urandom()), a);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GROW) shadow_grow = val & 32'hFFFF;
    else shadow_limit = val & 32'h1FFFF;
  endtask

  task automatic set_config(input logic [31:0] grow, input logic [31:0] lim);
    write_reg(CFG_GROW, grow);
    write_reg(CFG_LIMIT, lim);
  endtask

  // Pick a mostly small request size, rarely a huge one
  function automatic logic [15:0] pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 16'($urandom_range(1, 128));
    if (sel < 93) return 16'($urandom_range(129, 2000));
    if (sel < 98) return 16'($urandom_range(2001, 9000));
    if (sel < 99) return 16'd0;
    return 16'($urandom_range(9001, 65535));
  endfunction

  task automatic random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 45) send_free_live();
      else send_alloc(pick_size());
    end
  endtask

  task automatic free_all();
    while (live_blocks.size() != 0) send_free_live();
  endtask

  // Zero size, exact fit, split boundary, growth and out of memory
  task automatic test_directed();
    send_alloc(16'd0);
    send_alloc(16'd4088);
    send_alloc(16'd1);
    free_all();
    send_alloc(16'd4072);
    send_alloc(16'd1);
    free_all();
    send_alloc(16'd4073);
    send_alloc(16'd65535);
    send_alloc(16'd5000);
    send_alloc(16'd8);
    send_alloc(16'd9);
    free_all();
    send_alloc(16'hFFFF);
    send_alloc(16'h8000);
    send_alloc(16'h7FFF);
    free_all();
    drain();
  endtask

  task automatic test_config_sweep();
    set_config(32'd8, 32'd65536);
    random_mix(120);
    free_all();
    drain();
    // A grow step that is not a multiple of 4 gets trimmed to one, then rounded up to 8
    set_config(32'd14, 32'd30000);
    random_mix(120);
    free_all();
    drain();
    set_config(32'd32768, 32'd65536);
    random_mix(80);
    free_all();
    drain();
    set_config(32'd4096, 32'd4112);
    random_mix(60);
    free_all();
    drain();
    set_config(32'd1000, 32'd65535);
  endtask

  task automatic test_random();
    random_mix(200);
    drain();
  endtask

  // Hold off the receiver so the block backs up its input
  task automatic test_backpressure();
    hold_cycles = 600;
    random_mix(30);
    drain();
  endtask

  // Unchecked frees of arbitrary addresses, then keep going
  task automatic test_invalid_free();
    for (int i = 0; i < 3; i++) send_item(OP_FREE, 16'($urandom()), 16'($urandom()));
    random_mix(20);
    drain();
  endtask

  task automatic test_tail();
    no_idle = 1'b1;
    random_mix(60);
    drain();
  endtask

  initial begin
    shadow_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_config(32'd4096, 32'd65536);
    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    test_invalid_free();
    test_tail();
    repeat (100) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
